// ----- hw/rtl/ahtg_pkg.sv -----
// Shared types, constants and constant tables of the additive harmonic tone generator.
// Holds the pitch increment ROM and quarter-wave sine ROM, built at elaboration.
// No dependencies.
package ahtg_pkg;

    localparam int SAMPLE_RATE     = 44100;
    localparam int HARMONICS       = 8;
    localparam int NOTE_COUNT      = 128;
    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);

    localparam int NOTE_W   = 7;
    localparam int SAMPLE_W = 19;
    localparam int CFG_W    = 16;
    localparam int PHASE_W  = 32;
    localparam int GAIN_W   = 16;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam int UNITY_GAIN = 32768;
    localparam int OUT_MAX    = 262143;
    localparam int OUT_MIN    = -262144;

    localparam logic [CFG_W-1:0] GAIN_LOW_RST    = 16'd8192;
    localparam logic [CFG_W-1:0] GAIN_HIGH_RST   = 16'd32768;
    localparam logic [CFG_W-1:0] SWAP_PERIOD_RST = 16'd4410;

    localparam longint unsigned DEC_SCALE = 64'd1000000000;
    localparam longint unsigned PITCH_DEN = 64'(SAMPLE_RATE) * DEC_SCALE;
    localparam longint unsigned REF_PITCH = 64'd440;

    localparam longint signed PC1 = 64'sd1686629713;
    localparam longint signed PC3 = -64'sd693598668;
    localparam longint signed PC5 = 64'sd85569306;
    localparam longint signed PC7 = -64'sd5026995;
    localparam longint signed PC9 = 64'sd172272;

    typedef enum logic [1:0] {
        REG_GAIN_LOW    = 2'd0,
        REG_GAIN_HIGH   = 2'd1,
        REG_SWAP_PERIOD = 2'd2
    } ahtg_reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_RUN,
        ST_DONE
    } ahtg_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] gain_low;
        logic [CFG_W-1:0] gain_high;
        logic [CFG_W-1:0] swap_period;
    } ahtg_cfg_t;

    typedef logic [PHASE_W-1:0] inc_rom_t [NOTE_COUNT];
    typedef logic [GAIN_W-1:0] sine_rom_t [QUARTER+1];

    typedef longint unsigned ratio_t [12];
    localparam ratio_t SEMITONE_RATIO = '{
        64'd1000000000, 64'd1059463094, 64'd1122462048, 64'd1189207115,
        64'd1259921050, 64'd1334839854, 64'd1414213562, 64'd1498307077,
        64'd1587401052, 64'd1681792831, 64'd1781797436, 64'd1887748625
    };

    function automatic inc_rom_t build_inc_rom();
        inc_rom_t rom;
        longint unsigned num;
        longint unsigned q;
        longint unsigned r;
        int t;
        int sh;
        for (int n = 0; n < NOTE_COUNT; n++) begin
            t   = n + 3;
            sh  = 26 + t / 12;
            num = REF_PITCH * SEMITONE_RATIO[t % 12];
            q   = num / PITCH_DEN;
            r   = num % PITCH_DEN;
            for (int i = 0; i < sh; i++) begin
                q = q << 1;
                r = r << 1;
                if (r >= PITCH_DEN) begin
                    q = q + 64'd1;
                    r = r - PITCH_DEN;
                end
            end
            if (2 * r >= PITCH_DEN) begin
                q = q + 64'd1;
            end
            rom[n] = q[PHASE_W-1:0];
        end
        return rom;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        longint signed z;
        longint signed z2;
        longint signed p;
        longint signed v;
        for (int w = 0; w <= QUARTER; w++) begin
            z  = longint'(w) <<< (30 - (SINE_TABLE_BITS - 2));
            z2 = (z * z) >>> 30;
            p  = PC9;
            p  = PC7 + ((p * z2) >>> 30);
            p  = PC5 + ((p * z2) >>> 30);
            p  = PC3 + ((p * z2) >>> 30);
            p  = PC1 + ((p * z2) >>> 30);
            v  = (((p * z) >>> 30) + 64'sd16384) >>> 15;
            if (v > longint'(UNITY_GAIN)) begin
                v = longint'(UNITY_GAIN);
            end
            if (v < 0) begin
                v = 0;
            end
            rom[w] = v[GAIN_W-1:0];
        end
        return rom;
    endfunction

    localparam inc_rom_t  INC_ROM  = build_inc_rom();
    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- hw/rtl/ahtg_apb_regs.sv -----
// APB configuration registers: gain_low, gain_high, swap_period.
// Depends on ahtg_pkg.
module ahtg_apb_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ahtg_pkg::APB_AW-1:0]   paddr,
    input  logic [ahtg_pkg::APB_DW-1:0]   pwdata,
    output logic [ahtg_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output ahtg_pkg::ahtg_cfg_t           cfg
);

    ahtg_pkg::ahtg_cfg_t cfg_reg;
    logic                wr_en;
    logic [1:0]          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_low    <= ahtg_pkg::GAIN_LOW_RST;
            cfg_reg.gain_high   <= ahtg_pkg::GAIN_HIGH_RST;
            cfg_reg.swap_period <= ahtg_pkg::SWAP_PERIOD_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                ahtg_pkg::REG_GAIN_LOW:    cfg_reg.gain_low    <= pwdata[15:0];
                ahtg_pkg::REG_GAIN_HIGH:   cfg_reg.gain_high   <= pwdata[15:0];
                ahtg_pkg::REG_SWAP_PERIOD: cfg_reg.swap_period <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ahtg_pkg::REG_GAIN_LOW:    prdata = {16'd0, cfg_reg.gain_low};
            ahtg_pkg::REG_GAIN_HIGH:   prdata = {16'd0, cfg_reg.gain_high};
            ahtg_pkg::REG_SWAP_PERIOD: prdata = {16'd0, cfg_reg.swap_period};
            default:                   prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/ahtg_harm_unit.sv -----
// Shared harmonic unit: phase accumulator, quarter-wave sine lookup, gain multiply
// and sum, one harmonic issued per cycle. Depends on ahtg_pkg.
module ahtg_harm_unit #(
    parameter int HARMONICS = ahtg_pkg::HARMONICS
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    start,
    input  logic [ahtg_pkg::PHASE_W-1:0]            base,
    input  logic [ahtg_pkg::GAIN_W-1:0]             gain3,
    input  logic [ahtg_pkg::GAIN_W-1:0]             gain5,
    output logic                                    done,
    output logic signed [$clog2(HARMONICS)+18:0]    sum
);

    localparam int KW    = $clog2(HARMONICS);
    localparam int SUM_W = KW + 19;
    localparam int B     = ahtg_pkg::SINE_TABLE_BITS;
    localparam int GW    = ahtg_pkg::GAIN_W;

    logic                         iss_reg;
    logic [KW-1:0]                k_reg;
    logic [ahtg_pkg::PHASE_W-1:0] phase_reg;
    logic                         v1_reg;
    logic                         last1_reg;
    logic signed [GW:0]           sine_reg;
    logic [GW-1:0]                gain_reg;
    logic                         v2_reg;
    logic                         last2_reg;
    logic signed [2*GW+1:0]       prod_reg;
    logic signed [SUM_W-1:0]      acc_reg;
    logic                         done_reg;

    logic [B-1:0]        idx;
    logic [1:0]          quad;
    logic [B-3:0]        u;
    logic [B-2:0]        w;
    logic [GW-1:0]       mag;
    logic signed [GW:0]  sine;
    logic [GW-1:0]       gain;
    logic                k_last;
    logic signed [2*GW+1:0] rnd;
    logic signed [18:0]  term;

    assign idx    = phase_reg[ahtg_pkg::PHASE_W-1 -: B];
    assign quad   = idx[B-1 -: 2];
    assign u      = idx[B-3:0];
    assign w      = quad[0] ? ((B-1)'(ahtg_pkg::QUARTER) - {1'b0, u}) : {1'b0, u};
    assign mag    = ahtg_pkg::SINE_ROM[w];
    assign sine   = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign k_last = (k_reg == KW'(HARMONICS - 1));
    assign rnd    = prod_reg + (2*GW+2)'(16384);
    assign term   = rnd[33:15];
    assign done   = done_reg;
    assign sum    = acc_reg;

    always_comb begin
        if (32'(k_reg) == 32'd3) begin
            gain = gain3;
        end else if (32'(k_reg) == 32'd5) begin
            gain = gain5;
        end else begin
            gain = GW'(ahtg_pkg::UNITY_GAIN);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_reg  <= 1'b0;
            k_reg    <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= iss_reg;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg && last2_reg;
            if (start) begin
                iss_reg <= 1'b1;
                k_reg   <= '0;
            end else if (iss_reg) begin
                k_reg <= k_reg + KW'(1);
                if (k_last) begin
                    iss_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        sine_reg  <= sine;
        gain_reg  <= gain;
        last1_reg <= k_last;
        prod_reg  <= $signed({1'b0, gain_reg}) * sine_reg;
        last2_reg <= last1_reg;
        if (start) begin
            phase_reg <= '0;
            acc_reg   <= '0;
        end else begin
            if (iss_reg) begin
                phase_reg <= phase_reg + base;
            end
            if (v2_reg) begin
                acc_reg <= acc_reg + SUM_W'(term);
            end
        end
    end

endmodule

// ----- hw/rtl/additive_harmonic_tone_generator_top.sv -----
// Additive harmonic tone generator, top level: stream channels, sequencer, sample and
// swap counters, output register. Depends on ahtg_pkg, ahtg_apb_regs, ahtg_harm_unit.
//
// Each s_ transaction is one sample tick carrying a note number in s_tdata[6:0].
// The block answers with one m_ transaction holding the signed Q4.15 sum of
// HARMONICS weighted harmonic sines in m_tdata[18:0].
// Per tick: the 32x32 base-phase multiply is registered in ST_BASE, then the shared
// harmonic unit issues one harmonic per cycle and drains a three-stage lookup,
// multiply and accumulate pipeline; the finished sum is saturated to the sample range.
// A new tick is taken only after the previous sum has left the harmonic unit.
// s_tready is low while a tick is in work.
// The result sits in an output register, so the next tick is accepted while the
// previous result waits; if m_tready stays low, a finished sum is held in the unit
// until the output register frees up.
// Reset clears the sample counter, the swap counter and flag, and loads the
// register defaults (gain_low 0.25, gain_high 1.0, swap_period 4410). Configuration
// goes via the APB port only while the block is idle, which the user must ensure.
module additive_harmonic_tone_generator_top #(
    parameter int HARMONICS = ahtg_pkg::HARMONICS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [6:0] note_number
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [18:0] sample_out
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ahtg_pkg::APB_AW-1:0]   paddr,
    input  logic [ahtg_pkg::APB_DW-1:0]   pwdata,
    output logic [ahtg_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int SUM_W = $clog2(HARMONICS) + 19;
    localparam int GW    = ahtg_pkg::GAIN_W;
    localparam int PW    = ahtg_pkg::PHASE_W;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(ahtg_pkg::OUT_MAX);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(ahtg_pkg::OUT_MIN);

    ahtg_pkg::ahtg_cfg_t    cfg;
    ahtg_pkg::ahtg_state_t  state_reg;
    ahtg_pkg::ahtg_state_t  state_next;

    logic [PW-1:0]                  sample_count_reg;
    logic [ahtg_pkg::CFG_W-1:0]     swap_count_reg;
    logic [ahtg_pkg::CFG_W-1:0]     swap_count_next;
    logic                           swap_flag_reg;
    logic                           swap_flag_next;
    logic [PW-1:0]                  inc_reg;
    logic [PW-1:0]                  count_reg;
    logic [PW-1:0]                  base_reg;
    logic [GW-1:0]                  gain3_reg;
    logic [GW-1:0]                  gain5_reg;
    logic                           m_tvalid_reg;
    logic [ahtg_pkg::SAMPLE_W-1:0]  sample_reg;

    logic                           accept;
    logic                           out_free;
    logic                           load_out;
    logic                           start;
    logic                           done;
    logic signed [SUM_W-1:0]        sum;
    logic [ahtg_pkg::SAMPLE_W-1:0]  sat;
    logic [ahtg_pkg::NOTE_W-1:0]    note;
    logic [ahtg_pkg::NOTE_W-1:0]    note_idx;
    logic [GW-1:0]                  lo;
    logic [GW-1:0]                  hi;
    logic [ahtg_pkg::CFG_W-1:0]     period;
    logic [ahtg_pkg::CFG_W-1:0]     swap_inc;
    logic [2*PW-1:0]                base_full;

    ahtg_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ahtg_harm_unit #(
        .HARMONICS (HARMONICS)
    ) u_harm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .base    (base_reg),
        .gain3   (gain3_reg),
        .gain5   (gain5_reg),
        .done    (done),
        .sum     (sum)
    );

    assign s_tready  = (state_reg == ahtg_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign start     = (state_reg == ahtg_pkg::ST_BASE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {5'd0, sample_reg};
    assign base_full = inc_reg * count_reg;

    assign note     = s_tdata[ahtg_pkg::NOTE_W-1:0];
    assign note_idx = (32'(note) >= ahtg_pkg::NOTE_COUNT)
                    ? ahtg_pkg::NOTE_W'(ahtg_pkg::NOTE_COUNT - 1) : note;
    assign lo = (32'(cfg.gain_low) > ahtg_pkg::UNITY_GAIN)
              ? GW'(ahtg_pkg::UNITY_GAIN) : cfg.gain_low;
    assign hi = (32'(cfg.gain_high) > ahtg_pkg::UNITY_GAIN)
              ? GW'(ahtg_pkg::UNITY_GAIN) : cfg.gain_high;

    assign period   = (cfg.swap_period == '0) ? 16'd1 : cfg.swap_period;
    assign swap_inc = swap_count_reg + 16'd1;

    always_comb begin
        if (swap_inc >= period || swap_inc == '0) begin
            swap_count_next = '0;
            swap_flag_next  = !swap_flag_reg;
        end else begin
            swap_count_next = swap_inc;
            swap_flag_next  = swap_flag_reg;
        end
    end

    always_comb begin
        if (sum > SAT_MAX) begin
            sat = ahtg_pkg::SAMPLE_W'(SAT_MAX);
        end else if (sum < SAT_MIN) begin
            sat = ahtg_pkg::SAMPLE_W'(SAT_MIN);
        end else begin
            sat = sum[ahtg_pkg::SAMPLE_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ahtg_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = ahtg_pkg::ST_BASE;
                end
            end
            ahtg_pkg::ST_BASE: begin
                state_next = ahtg_pkg::ST_RUN;
            end
            ahtg_pkg::ST_RUN: begin
                if (done) begin
                    if (out_free) begin
                        load_out   = 1'b1;
                        state_next = ahtg_pkg::ST_IDLE;
                    end else begin
                        state_next = ahtg_pkg::ST_DONE;
                    end
                end
            end
            ahtg_pkg::ST_DONE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ahtg_pkg::ST_IDLE;
                end
            end
            default: state_next = ahtg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ahtg_pkg::ST_IDLE;
            sample_count_reg <= '0;
            swap_count_reg   <= '0;
            swap_flag_reg    <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                sample_count_reg <= sample_count_reg + 32'd1;
                swap_count_reg   <= swap_count_next;
                swap_flag_reg    <= swap_flag_next;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            inc_reg   <= ahtg_pkg::INC_ROM[note_idx];
            count_reg <= sample_count_reg;
            gain3_reg <= swap_flag_reg ? lo : hi;
            gain5_reg <= swap_flag_reg ? hi : lo;
        end
        if (state_reg == ahtg_pkg::ST_BASE) begin
            base_reg <= base_full[PW-1:0];
        end
        if (load_out) begin
            sample_reg <= sat;
        end
    end

endmodule
